### hw/rtl/psf_pkg.sv
package psf_pkg;

  localparam int UNIT_BITS = 60;
  localparam int MUL_STEPS = 36;
  localparam int DIV_STEPS = 128;
  localparam int SQRT_STEPS = 36;
  localparam int SQRT_ALIGN = 128 - 2 * SQRT_STEPS;
  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam int NUM_SUMS = 9;
  localparam int IDX_W = 4;

  typedef logic signed [63:0] sum_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] result;
  } alu_rsp_t;

  typedef struct packed {
    logic             add;
    logic             clr;
    logic [IDX_W-1:0] idx;
    sum_t             term;
  } acc_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_SQRT,
    S_CUBE,
    S_FMUL,
    S_FDIV,
    S_WMUL,
    S_WDIV,
    S_GMUL,
    S_GDIV,
    S_EMIT
  } seq_state_t;

  function automatic logic [1:0] pair_a(input logic [2:0] k);
    logic [1:0] r;
    unique case (k)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_b(input logic [2:0] k);
    logic [1:0] r;
    unique case (k)
      3'd0:       r = 2'd0;
      3'd1, 3'd3: r = 2'd1;
      default:    r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic sum_t sat_term(input logic [127:0] q, input logic neg);
    logic [63:0] m;
    m = (|q[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
    return neg ? sum_t'(-m) : sum_t'(m);
  endfunction

  function automatic sum_t sat_add(input sum_t a, input sum_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? sum_t'(64'h8000_0000_0000_0000) : sum_t'(64'h7FFF_FFFF_FFFF_FFFF);
    end
    return sum_t'(s[63:0]);
  endfunction

  function automatic logic [47:0] out48(input sum_t v);
    if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
      return 48'h7FFF_FFFF_FFFF;
    end else if (v < -64'sh0000_8000_0000_0000) begin
      return 48'h8000_0000_0000;
    end
    return v[47:0];
  endfunction

endpackage

### hw/rtl/psf_ifs.sv
interface psf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] probe_x;
  logic signed [31:0] probe_y;
  logic signed [31:0] probe_z;
  logic signed [31:0] src_x;
  logic signed [31:0] src_y;
  logic signed [31:0] src_z;
  logic [31:0]        src_mass;
  logic               has_source;
  logic               last_source;

  modport source (output valid, probe_x, probe_y, probe_z, src_x, src_y, src_z,
                  src_mass, has_source, last_source, input ready);
  modport sink (input valid, probe_x, probe_y, probe_z, src_x, src_y, src_z,
                src_mass, has_source, last_source, output ready);
endinterface

interface psf_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] field_x;
  logic signed [47:0] field_y;
  logic signed [47:0] field_z;
  logic signed [47:0] grad_xx;
  logic signed [47:0] grad_xy;
  logic signed [47:0] grad_xz;
  logic signed [47:0] grad_yy;
  logic signed [47:0] grad_yz;
  logic signed [47:0] grad_zz;

  modport source (output valid, field_x, field_y, field_z, grad_xx, grad_xy, grad_xz,
                  grad_yy, grad_yz, grad_zz, input ready);
  modport sink (input valid, field_x, field_y, field_z, grad_xx, grad_xy, grad_xz,
                grad_yy, grad_yz, grad_zz, output ready);
endinterface

### hw/rtl/psf_alu.sv
module psf_alu
  import psf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  alu_req_t     req,
  input  logic [127:0] opa,
  input  logic [127:0] opb,
  output alu_rsp_t     rsp
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  alu_op_t          op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [127:0]     acc_r, acc_nxt;
  logic [127:0]     a_r, a_nxt;
  logic [127:0]     b_r, b_nxt;
  logic [127:0]     d_r, d_nxt;

  logic [128:0] add_x, add_y, add_s;
  logic         add_cin;
  logic [127:0] rs_div, rs_sq, trial;
  logic         ge;

  always_comb begin
    rs_div = {acc_r[126:0], a_r[127]};
    rs_sq  = {acc_r[125:0], a_r[127:126]};
    trial  = {b_r[125:0], 2'b01};
    unique case (op_r)
      ALU_MUL: begin
        add_x   = {1'b0, acc_r};
        add_y   = {1'b0, b_r[0] ? a_r : 128'd0};
        add_cin = 1'b0;
      end
      ALU_DIV: begin
        add_x   = {1'b0, rs_div};
        add_y   = {1'b1, ~d_r};
        add_cin = 1'b1;
      end
      default: begin
        add_x   = {1'b0, rs_sq};
        add_y   = {1'b1, ~trial};
        add_cin = 1'b1;
      end
    endcase
    add_s = add_x + add_y + {128'd0, add_cin};
    ge    = ~add_s[128];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    d_nxt    = d_r;
    if (!busy_r) begin
      if (req.start) begin
        busy_nxt = 1'b1;
        op_nxt   = req.op;
        acc_nxt  = '0;
        d_nxt    = opb;
        unique case (req.op)
          ALU_MUL: begin
            a_nxt   = opa;
            b_nxt   = opb;
            cnt_nxt = CNT_W'(MUL_STEPS - 1);
          end
          ALU_DIV: begin
            a_nxt   = opa;
            b_nxt   = '0;
            cnt_nxt = CNT_W'(DIV_STEPS - 1);
          end
          default: begin
            a_nxt   = opa << SQRT_ALIGN;
            b_nxt   = '0;
            cnt_nxt = CNT_W'(SQRT_STEPS - 1);
          end
        endcase
      end
    end else begin
      unique case (op_r)
        ALU_MUL: begin
          acc_nxt = add_s[127:0];
          a_nxt   = a_r << 1;
          b_nxt   = b_r >> 1;
        end
        ALU_DIV: begin
          acc_nxt = ge ? add_s[127:0] : rs_div;
          a_nxt   = a_r << 1;
          b_nxt   = {b_r[126:0], ge};
        end
        default: begin
          acc_nxt = ge ? add_s[127:0] : rs_sq;
          a_nxt   = a_r << 2;
          b_nxt   = {b_r[126:0], ge};
        end
      endcase
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= ALU_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    d_r   <= d_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = (op_r == ALU_MUL) ? acc_r : b_r;

endmodule

### hw/rtl/psf_acc.sv
module psf_acc
  import psf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  acc_req_t req,
  output sum_t     sums [NUM_SUMS]
);

  sum_t sum_r [NUM_SUMS];
  sum_t sum_nxt [NUM_SUMS];

  always_comb begin
    for (int i = 0; i < NUM_SUMS; i++) begin
      sum_nxt[i] = sum_r[i];
      if (req.clr) begin
        sum_nxt[i] = '0;
      end else if (req.add && (req.idx == IDX_W'(i))) begin
        sum_nxt[i] = sat_add(sum_r[i], req.term);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SUMS; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_SUMS; i++) begin
        sum_r[i] <= sum_nxt[i];
      end
    end
  end

  assign sums = sum_r;

endmodule

### hw/rtl/point_source_field_and_tidal_tensor_core.sv
// Sums the softened field and gradient tensor of a stream of point sources at one probe
// point and emits the nine sums as one word on the source marked last. The multiplies,
// divides and square root run on one shared 129-bit add/subtract unit stepped by a
// sequencer: a present source takes twenty 36-step multiplies, fifteen 128-step divides
// and one 36-step square root, and a new source is accepted only once it is through.
// An absent source starts no arithmetic. A source marked last is followed by a state that
// emits the sums, which waits while the previous word is not taken.
module point_source_field_and_tidal_tensor_core
  import psf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  psf_in_if.sink      in_ch,
  psf_out_if.source   out_ch
);

  localparam int FSH  = 2 * FRAC_BITS;
  localparam int GSH  = 3 * FRAC_BITS - UNIT_BITS;
  localparam int GSHL = (GSH > 0) ? GSH : 0;
  localparam int GSHR = (GSH < 0) ? -GSH : 0;

  seq_state_t   state_r, state_nxt;
  logic         issued_r, issued_nxt;
  logic [2:0]   j_r, j_nxt;
  logic [31:0]  softening_r, softening_nxt;
  logic [32:0]  ad_r [4];
  logic [32:0]  ad_nxt [4];
  logic [2:0]   nd_r, nd_nxt;
  logic [31:0]  mass_r, mass_nxt;
  logic         last_r, last_nxt;
  logic [67:0]  r2_r, r2_nxt;
  logic [33:0]  root_r, root_nxt;
  logic [101:0] r3_r, r3_nxt;
  logic [127:0] prod_r, prod_nxt;
  logic [62:0]  mag_r, mag_nxt;
  logic         neg_r, neg_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [47:0]  out_r [NUM_SUMS];
  logic [47:0]  out_nxt [NUM_SUMS];

  alu_req_t     alu_req;
  alu_rsp_t     alu_rsp;
  logic [127:0] alu_a, alu_b;
  acc_req_t     acc_req;
  sum_t         sums [NUM_SUMS];

  logic signed [32:0] d_in [3];
  logic [1:0]   pa, pb;
  logic [67:0]  r2_sum;
  logic [60:0]  w;
  logic [62:0]  w3;
  logic [127:0] gq;

  localparam logic [62:0] UNIT = 63'(1) << UNIT_BITS;

  psf_alu u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (alu_req),
    .opa  (alu_a),
    .opb  (alu_b),
    .rsp  (alu_rsp)
  );

  psf_acc u_acc (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (acc_req),
    .sums (sums)
  );

  always_comb begin
    d_in[0] = {in_ch.probe_x[31], in_ch.probe_x} - {in_ch.src_x[31], in_ch.src_x};
    d_in[1] = {in_ch.probe_y[31], in_ch.probe_y} - {in_ch.src_y[31], in_ch.src_y};
    d_in[2] = {in_ch.probe_z[31], in_ch.probe_z} - {in_ch.src_z[31], in_ch.src_z};
    pa      = pair_a(j_r);
    pb      = pair_b(j_r);
    r2_sum  = r2_r + alu_rsp.result[67:0];
    w       = alu_rsp.result[60:0];
    w3      = {1'b0, w, 1'b0} + {2'b00, w};
    gq      = alu_rsp.result >> GSHR;
  end

  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    j_nxt         = j_r;
    softening_nxt = softening_r;
    ad_nxt        = ad_r;
    nd_nxt        = nd_r;
    mass_nxt      = mass_r;
    last_nxt      = last_r;
    r2_nxt        = r2_r;
    root_nxt      = root_r;
    r3_nxt        = r3_r;
    prod_nxt      = prod_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_a         = '0;
    alu_b         = '0;
    acc_req.add   = 1'b0;
    acc_req.clr   = 1'b0;
    acc_req.idx   = '0;
    acc_req.term  = '0;

    if (cfg_we) begin
      softening_nxt = cfg_wdata;
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_SQ: begin
        alu_a = {95'd0, ad_r[j_r[1:0]]};
        alu_b = {95'd0, ad_r[j_r[1:0]]};
      end
      S_SQRT: begin
        alu_req.op = ALU_SQRT;
        alu_a      = {60'd0, r2_r};
      end
      S_CUBE: begin
        alu_a = {60'd0, r2_r};
        alu_b = {94'd0, root_r};
      end
      S_FMUL: begin
        alu_a = {95'd0, ad_r[j_r[1:0]]};
        alu_b = {96'd0, mass_r};
      end
      S_FDIV: begin
        alu_req.op = ALU_DIV;
        alu_a      = prod_r << FSH;
        alu_b      = {26'd0, r3_r};
      end
      S_WMUL: begin
        alu_a = {95'd0, ad_r[pa]};
        alu_b = {95'd0, ad_r[pb]};
      end
      S_WDIV: begin
        alu_req.op = ALU_DIV;
        alu_a      = prod_r << UNIT_BITS;
        alu_b      = {60'd0, r2_r};
      end
      S_GMUL: begin
        alu_a = {65'd0, mag_r};
        alu_b = {96'd0, mass_r};
      end
      S_GDIV: begin
        alu_req.op = ALU_DIV;
        alu_a      = prod_r << GSHL;
        alu_b      = {26'd0, r3_r};
      end
      default: begin
      end
    endcase

    if (state_r != S_IDLE && state_r != S_EMIT) begin
      if (!issued_r) begin
        alu_req.start = 1'b1;
        issued_nxt    = 1'b1;
      end else if (alu_rsp.done) begin
        issued_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          for (int i = 0; i < 3; i++) begin
            nd_nxt[i] = d_in[i][32];
            ad_nxt[i] = d_in[i][32] ? 33'(-d_in[i]) : 33'(d_in[i]);
          end
          ad_nxt[3] = {1'b0, softening_r};
          mass_nxt  = in_ch.src_mass;
          last_nxt  = in_ch.last_source;
          r2_nxt    = '0;
          j_nxt     = '0;
          if (in_ch.has_source) begin
            state_nxt = S_SQ;
          end else if (in_ch.last_source) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_SQ: begin
        if (issued_r && alu_rsp.done) begin
          r2_nxt = r2_sum;
          if (j_r == 3'd3) begin
            j_nxt     = '0;
            state_nxt = S_SQRT;
            if (r2_sum == '0) begin
              r2_nxt = 68'd1;
            end
          end else begin
            j_nxt = j_r + 3'd1;
          end
        end
      end
      S_SQRT: begin
        if (issued_r && alu_rsp.done) begin
          root_nxt  = alu_rsp.result[33:0];
          state_nxt = S_CUBE;
        end
      end
      S_CUBE: begin
        if (issued_r && alu_rsp.done) begin
          r3_nxt    = alu_rsp.result[101:0];
          state_nxt = S_FMUL;
        end
      end
      S_FMUL: begin
        if (issued_r && alu_rsp.done) begin
          prod_nxt  = alu_rsp.result;
          state_nxt = S_FDIV;
        end
      end
      S_FDIV: begin
        if (issued_r && alu_rsp.done) begin
          acc_req.add  = 1'b1;
          acc_req.idx  = IDX_W'(j_r);
          acc_req.term = sat_term(alu_rsp.result, nd_r[j_r[1:0]]);
          if (j_r == 3'd2) begin
            j_nxt     = '0;
            state_nxt = S_WMUL;
          end else begin
            j_nxt     = j_r + 3'd1;
            state_nxt = S_FMUL;
          end
        end
      end
      S_WMUL: begin
        if (issued_r && alu_rsp.done) begin
          prod_nxt  = alu_rsp.result;
          state_nxt = S_WDIV;
        end
      end
      S_WDIV: begin
        if (issued_r && alu_rsp.done) begin
          if (pa == pb) begin
            if (w3 > UNIT) begin
              mag_nxt = w3 - UNIT;
              neg_nxt = 1'b1;
            end else begin
              mag_nxt = UNIT - w3;
              neg_nxt = 1'b0;
            end
          end else begin
            mag_nxt = w3;
            neg_nxt = (nd_r[pa] == nd_r[pb]);
          end
          state_nxt = S_GMUL;
        end
      end
      S_GMUL: begin
        if (issued_r && alu_rsp.done) begin
          prod_nxt  = alu_rsp.result;
          state_nxt = S_GDIV;
        end
      end
      S_GDIV: begin
        if (issued_r && alu_rsp.done) begin
          acc_req.add  = 1'b1;
          acc_req.idx  = IDX_W'(j_r) + IDX_W'(3);
          acc_req.term = sat_term(gq, neg_r);
          if (j_r == 3'd5) begin
            j_nxt     = '0;
            state_nxt = last_r ? S_EMIT : S_IDLE;
          end else begin
            j_nxt     = j_r + 3'd1;
            state_nxt = S_WMUL;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          for (int i = 0; i < NUM_SUMS; i++) begin
            out_nxt[i] = out48(sums[i]);
          end
          out_valid_nxt = 1'b1;
          acc_req.clr   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      j_r         <= '0;
      softening_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      j_r         <= j_nxt;
      softening_r <= softening_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ad_r   <= ad_nxt;
    nd_r   <= nd_nxt;
    mass_r <= mass_nxt;
    last_r <= last_nxt;
    r2_r   <= r2_nxt;
    root_r <= root_nxt;
    r3_r   <= r3_nxt;
    prod_r <= prod_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    out_r  <= out_nxt;
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.field_x = $signed(out_r[0]);
  assign out_ch.field_y = $signed(out_r[1]);
  assign out_ch.field_z = $signed(out_r[2]);
  assign out_ch.grad_xx = $signed(out_r[3]);
  assign out_ch.grad_xy = $signed(out_r[4]);
  assign out_ch.grad_xz = $signed(out_r[5]);
  assign out_ch.grad_yy = $signed(out_r[6]);
  assign out_ch.grad_yz = $signed(out_r[7]);
  assign out_ch.grad_zz = $signed(out_r[8]);

endmodule
